// ----- design/lfng_pkg.sv -----
`timescale 1ns / 1ps
package lfng_pkg;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int STR_W = 19;
    localparam logic [17:0] GAIN_ONE = 18'd65536;
    localparam logic [17:0] GAIN_MIN = 18'd19661;
    localparam logic [17:0] GAIN_MAX = 18'd262143;
    localparam logic signed [24:0] GUTTER_TH = 25'sd5033165;

    typedef enum logic [1:0] {
        K_NONE = 2'd0, K_FIRE = 2'd1, K_CANDLE = 2'd2, K_GENTLE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] time_now;
        logic [31:0] owner_id;
        logic [31:0] light_index;
        logic [1:0]  flicker_kind;
        logic [31:0] intensity_in;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
    } t_req;

    typedef struct packed {
        logic [17:0] gain_out;
        logic [31:0] intensity_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
    } t_res;

    // per-kind octave frequency (Q.16); lanes 0..2 main, 3 gutter, 4..6 jitter
    function automatic logic [19:0] oct_freq(input logic [1:0] kind, input int lane);
        logic [19:0] f;
        f = 20'd0;
        unique case (kind)
            K_FIRE: begin
                if (lane == 0) f = 20'd85197;
                else if (lane == 1) f = 20'd242483;
                else if (lane == 2) f = 20'd596378;
                else if (lane == 3) f = 20'd45875;
                else f = 20'd150733;
            end
            K_CANDLE: begin
                if (lane == 0) f = 20'd517734;
                else f = 20'd1002701;
            end
            default: begin
                if (lane == 0) f = 20'd58982;
                else f = 20'd203162;
            end
        endcase
        return f;
    endfunction

    function automatic logic signed [14:0] oct_weight(input logic [1:0] kind, input int lane);
        logic signed [14:0] w;
        w = 15'sd0;
        unique case (kind)
            K_FIRE: begin
                if (lane == 0) w = 15'sd9175;
                else if (lane == 1) w = 15'sd5898;
                else if (lane == 2) w = 15'sd3277;
            end
            K_CANDLE: begin
                if (lane == 0) w = 15'sd3277;
                else if (lane == 1) w = 15'sd1966;
            end
            default: begin
                if (lane == 0) w = 15'sd1311;
                else if (lane == 1) w = 15'sd655;
            end
        endcase
        return w;
    endfunction
endpackage

// ----- design/lfng_noise.sv -----
`timescale 1ns / 1ps
// one value-noise octave, 7 register stages
module lfng_noise import lfng_pkg::*; #(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic [31:0]        i_time,
    input  logic [19:0]        i_freq,
    input  logic [31:0]        i_seed,
    output logic signed [24:0] o_noise
);
    localparam int PW = 52;
    logic [PW-1:0] r_p;
    logic [31:0] r_seed1, r_cell, r_ck, r_sk, r_sk2, r_k;
    logic [15:0] r_f1, r_f2, r_f3, r_s;
    logic [31:0] r_ff;
    logic [17:0] r_tw;
    logic [31:0] r_a1, r_b1;
    logic [31:0] n_a1, n_b1;
    logic [23:0] n_a, n_b;
    logic [23:0] r_a, r_b;
    logic [PW-1:0] n_p;
    logic [23:0] n_m;
    logic signed [24:0] r_out;

    assign n_p = PW'(i_time) * PW'(i_freq);

    always_ff @(posedge i_clk) begin
        // s1: product
        r_p     <= n_p;
        r_seed1 <= i_seed;
        // s2: cell, seed products
        r_cell <= 32'(r_p >> (TIME_FRAC_BITS + 16));
        r_f1   <= r_p[TIME_FRAC_BITS +: 16];
        r_sk   <= 32'(r_seed1 * 32'h85EBCA77);
        // s3: cell product
        r_ck  <= 32'(r_cell * 32'h9E3779B1);
        r_sk2 <= r_sk;
        r_f2  <= r_f1;
        // s4: key
        r_k  <= r_ck + r_sk2;
        r_f3 <= r_f2;
        // s5: first mix round, smoothstep terms
        r_a1 <= n_a1;
        r_b1 <= n_b1;
        r_ff <= 32'(r_f3) * 32'(r_f3);
        r_tw <= 18'd196608 - {1'b0, r_f3, 1'b0};
        // s6: second mix round, smoothstep
        r_a <= n_a;
        r_b <= n_b;
        r_s <= 16'((64'(r_ff) * 64'(r_tw)) >> 32);
    end

    always_comb begin
        logic [31:0] x, y;
        x = r_k ^ (r_k >> 16);
        n_a1 = 32'(x * 32'h7FEB352D);
        y = (r_k + 32'h9E3779B1);
        y = y ^ (y >> 16);
        n_b1 = 32'(y * 32'h7FEB352D);
        x = r_a1 ^ (r_a1 >> 15);
        x = 32'(x * 32'h846CA68B);
        n_a = 24'(x ^ (x >> 16));
        y = r_b1 ^ (r_b1 >> 15);
        y = 32'(y * 32'h846CA68B);
        n_b = 24'(y ^ (y >> 16));
    end

    // s7: blend
    assign n_m = 24'((41'(r_a) * 41'(17'd65536 - 17'(r_s)) + 41'(r_b) * 41'(r_s)) >> 16);
    always_ff @(posedge i_clk) r_out <= $signed({1'b0, n_m}) - 25'sd8388608;
    assign o_noise = r_out;
endmodule

// ----- design/light_flicker_noise_generator.sv -----
`timescale 1ns / 1ps
// Light flicker noise generator: one light request per cycle, start is honored whenever
// busy is low and busy stays low, so a new request may enter every cycle. Each result
// appears on o_res for exactly one cycle with o_done high; the latency is set by the
// 32-bit hash multiplier chain of the noise octaves and the gain/jitter multipliers.
// The receiver cannot stall the block. The strength register may be written only while
// no request is in flight.
module light_flicker_noise_generator import lfng_pkg::*; #(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [STR_W-1:0] i_cfg_data,
    output logic             o_done,
    output t_res             o_res
);
    localparam int NL = 7;     // noise latency

    logic [STR_W-1:0] r_str;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_str <= STR_W'(65536);
        else if (i_cfg_we) r_str <= i_cfg_data;
    end
    assign busy = 1'b0;

    // seed (combinational at entry: two 32-bit multiplies, registered next)
    logic [31:0] r_seed;
    t_req r_req0;
    logic r_v0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else r_v0 <= start;
        r_req0 <= i_req;
        r_seed <= 32'(i_req.owner_id * 32'd2654435761) + 32'(i_req.light_index * 32'd40503);
    end

    // octave lanes
    logic signed [24:0] w_n [NL];
    for (genvar g = 0; g < NL; g++) begin : g_oct
        lfng_noise #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_noise (
            .i_clk  (i_clk),
            .i_time (r_req0.time_now),
            .i_freq (oct_freq(r_req0.flicker_kind, g)),
            .i_seed (r_seed + 32'(g)),
            .o_noise(w_n[g])
        );
    end

    // request delay line alongside the noise lanes
    t_req r_dl [NL];
    logic [NL-1:0] r_vdl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vdl <= '0;
        else r_vdl <= {r_vdl[NL-2:0], r_v0};
        r_dl[0] <= r_req0;
        for (int i = 1; i < NL; i++) r_dl[i] <= r_dl[i-1];
    end
    t_req rq;
    assign rq = r_dl[NL-1];

    // stage A: weighted sum (Q.39) and jitter products
    logic signed [47:0] r_v;
    logic signed [45:0] r_jp [3];
    t_req r_qa;
    logic r_va;
    logic [STR_W-1:0] r_sa;
    always_ff @(posedge i_clk) begin
        logic signed [47:0] v;
        logic signed [25:0] gt;
        v = 48'(oct_weight(rq.flicker_kind, 0)) * 48'(w_n[0])
          + 48'(oct_weight(rq.flicker_kind, 1)) * 48'(w_n[1])
          + 48'(oct_weight(rq.flicker_kind, 2)) * 48'(w_n[2]);
        gt = 26'(w_n[3]) - 26'(GUTTER_TH);
        if (rq.flicker_kind == K_FIRE && gt > 0) v = v - (48'(gt) <<< 15);
        r_v  <= v;
        for (int i = 0; i < 3; i++)
            r_jp[i] <= 46'(w_n[4+i]) * 46'sd1966;
        r_qa <= rq;
        r_sa <= r_str;
        if (!i_rst_n) r_va <= 1'b0;
        else r_va <= r_vdl[NL-1];
    end

    // stage B: times strength (the floor shift by 39 follows in stage C)
    logic signed [67:0] r_vs;
    logic signed [65:0] r_js [3];
    t_req r_qb;
    logic r_vb;
    logic [STR_W-1:0] r_sb;
    always_ff @(posedge i_clk) begin
        r_vs <= 68'(r_v) * $signed({1'b0, r_sa});
        for (int i = 0; i < 3; i++) r_js[i] <= 66'(r_jp[i]) * $signed({1'b0, r_sa});
        r_qb <= r_qa;
        r_sb <= r_sa;
        if (!i_rst_n) r_vb <= 1'b0;
        else r_vb <= r_va;
    end

    // stage C: gain clamp and jittered positions
    logic [17:0] r_gain;
    logic signed [33:0] r_pos [3];
    t_req r_qc;
    logic r_vc, r_byp;
    always_ff @(posedge i_clk) begin
        logic signed [28:0] gd;
        logic signed [29:0] gs;
        logic signed [33:0] p;
        logic signed [31:0] pin [3];
        pin[0] = r_qb.pos_x_in;
        pin[1] = r_qb.pos_y_in;
        pin[2] = r_qb.pos_z_in;
        r_byp <= (r_qb.flicker_kind == K_NONE) || (r_sb == '0);
        gd = 29'(r_vs >>> 39);
        gs = 30'(gd) + 30'sd65536;
        // signed compares, the gain sum can go negative
        if (gs < $signed(30'(GAIN_MIN))) r_gain <= GAIN_MIN;
        else if (gs > $signed(30'(GAIN_MAX))) r_gain <= GAIN_MAX;
        else r_gain <= 18'(gs);
        for (int i = 0; i < 3; i++) begin
            p = 34'(pin[i]);
            if (r_qb.flicker_kind == K_FIRE) p = p + 34'(r_js[i] >>> 39);
            r_pos[i] <= p;
        end
        r_qc <= r_qb;
        if (!i_rst_n) r_vc <= 1'b0;
        else r_vc <= r_vb;
    end

    // stage D: intensity scale and saturation
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        if (x > 34'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -34'sd2147483648) return 32'sh80000000;
        return 32'(x);
    endfunction

    always_ff @(posedge i_clk) begin
        logic [49:0] pr;
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= r_vc;
        pr = 50'(r_qc.intensity_in) * 50'(r_gain);
        if (r_byp) begin
            o_res.gain_out      <= GAIN_ONE;
            o_res.intensity_out <= r_qc.intensity_in;
            o_res.pos_x_out     <= r_qc.pos_x_in;
            o_res.pos_y_out     <= r_qc.pos_y_in;
            o_res.pos_z_out     <= r_qc.pos_z_in;
        end else begin
            o_res.gain_out      <= r_gain;
            o_res.intensity_out <= (pr[49:48] != 2'b00) ? 32'hFFFFFFFF : pr[47:16];
            o_res.pos_x_out     <= sat32(r_pos[0]);
            o_res.pos_y_out     <= sat32(r_pos[1]);
            o_res.pos_z_out     <= sat32(r_pos[2]);
        end
    end

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |=> o_done) else $error("lost result");
    a_nobusy: assert property (@(posedge i_clk) !busy) else $error("busy raised");
    a_gmin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.gain_out >= GAIN_MIN) else $error("gain below floor");
endmodule

// ----- dv/light_flicker_noise_generator_tb.sv -----
`timescale 1ns / 1ps
module light_flicker_noise_generator_tb;
    import lfng_pkg::*;

    localparam int LATENCY = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1300;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             i_cfg_we;
    logic [STR_W-1:0] i_cfg_data;
    logic             o_done;
    t_res             o_res;

    light_flicker_noise_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_res      (o_res)
    );

    // testbench copy of the strength register
    logic [STR_W-1:0] strength_shadow;
    t_res             pending_lights[$];
    int               n_errors;
    int               idle_cycles;
    bit               sent_any;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // 24-bit avalanche hash of one lattice point
    function automatic logic [23:0] hash24(input logic [31:0] x0);
        logic [31:0] x;
        x = x0;
        x = x ^ (x >> 16);
        x = x * 32'h7FEB352D;
        x = x ^ (x >> 15);
        x = x * 32'h846CA68B;
        x = x ^ (x >> 16);
        return x[23:0];
    endfunction

    // smoothstep value noise, q1.23
    function automatic longint value_noise(input logic [31:0] t, input logic [31:0] freq,
                                           input logic [31:0] seed);
        logic [63:0] p;
        logic [31:0] lat_pt, k;
        longint f, s, a, b, m;
        p = 64'(t) * 64'(freq);
        lat_pt = 32'(p >> 32);
        f = longint'((p >> 16) & 64'hFFFF);
        k = lat_pt * 32'h9E3779B1 + seed * 32'h85EBCA77;
        a = longint'(hash24(k));
        b = longint'(hash24(k + 32'h9E3779B1));
        s = longint'((64'(f * f) * 64'(196608 - 2 * f)) >> 32);
        m = (a * (65536 - s) + b * s) >>> 16;
        return m - 8388608;
    endfunction

    function automatic longint shr_floor(input longint x, input int sh);
        return x >>> sh;
    endfunction

    function automatic logic [31:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_res flicker_light(input t_req r, input logic [STR_W-1:0] str_reg);
        t_res   res;
        longint str, v, gain, g, j;
        longint pos[3];
        logic [31:0] seed;
        logic [63:0] iout;
        str = longint'(str_reg);
        pos[0] = longint'(r.pos_x_in);
        pos[1] = longint'(r.pos_y_in);
        pos[2] = longint'(r.pos_z_in);
        res.gain_out = GAIN_ONE;
        res.intensity_out = r.intensity_in;
        res.pos_x_out = r.pos_x_in;
        res.pos_y_out = r.pos_y_in;
        res.pos_z_out = r.pos_z_in;
        if (t_kind'(r.flicker_kind) == K_NONE || str == 0) return res;
        seed = r.owner_id * 32'd2654435761 + r.light_index * 32'd40503;
        unique case (t_kind'(r.flicker_kind))
            K_FIRE: begin
                v = 9175 * value_noise(r.time_now, 85197, seed)
                  + 5898 * value_noise(r.time_now, 242483, seed + 1)
                  + 3277 * value_noise(r.time_now, 596378, seed + 2);
                g = value_noise(r.time_now, 45875, seed + 3) - 5033165;
                if (g > 0) v -= 32768 * g;
                for (int a = 0; a < 3; a++) begin
                    j = shr_floor(1966 * str * value_noise(r.time_now, 150733, seed + 4 + a), 39);
                    pos[a] += j;
                end
            end
            K_CANDLE: v = 3277 * value_noise(r.time_now, 517734, seed)
                        + 1966 * value_noise(r.time_now, 1002701, seed + 1);
            default:  v = 1311 * value_noise(r.time_now, 58982, seed)
                        + 655 * value_noise(r.time_now, 203162, seed + 1);
        endcase
        gain = 65536 + shr_floor(v * str, 39);
        if (gain < 19661) gain = 19661;
        if (gain > 262143) gain = 262143;
        iout = (64'(r.intensity_in) * 64'(gain)) >> 16;
        if (iout > 64'hFFFFFFFF) iout = 64'hFFFFFFFF;
        res.gain_out = gain[17:0];
        res.intensity_out = iout[31:0];
        res.pos_x_out = clamp_pos(pos[0]);
        res.pos_y_out = clamp_pos(pos[1]);
        res.pos_z_out = clamp_pos(pos[2]);
        return res;
    endfunction

    // result checker and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && ((start && !busy) || o_done)) idle_cycles <= 0;
        else if (sent_any) idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_lights.size() == 0) begin
                $error("unexpected result %h", o_res);
                n_errors++;
            end else begin
                want = pending_lights.pop_front();
                if (o_res.gain_out !== want.gain_out) begin
                    $error("gain_out exp %h got %h", want.gain_out, o_res.gain_out);
                    n_errors++;
                end
                if (o_res.intensity_out !== want.intensity_out) begin
                    $error("intensity_out exp %h got %h", want.intensity_out, o_res.intensity_out);
                    n_errors++;
                end
                if (o_res.pos_x_out !== want.pos_x_out) begin
                    $error("pos_x_out exp %h got %h", want.pos_x_out, o_res.pos_x_out);
                    n_errors++;
                end
                if (o_res.pos_y_out !== want.pos_y_out) begin
                    $error("pos_y_out exp %h got %h", want.pos_y_out, o_res.pos_y_out);
                    n_errors++;
                end
                if (o_res.pos_z_out !== want.pos_z_out) begin
                    $error("pos_z_out exp %h got %h", want.pos_z_out, o_res.pos_z_out);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // drive one light request; start stays high for back-to-back requests
    task automatic send_light(input t_req r, input bit check_lit, input t_res lit);
        int gap;
        t_res want;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = check_lit ? lit : flicker_light(r, strength_shadow);
        pending_lights = {pending_lights, want};
        sent_any = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic drain_lights();
        start <= 1'b0;
        while (pending_lights.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_strength(input logic [STR_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        strength_shadow = val;
    endtask

    function automatic t_req rand_light();
        t_req r;
        r.time_now = $urandom();
        if ($urandom_range(0, 2) == 0) r.time_now = $urandom_range(0, 32'h000FFFFF);
        r.owner_id = $urandom();
        r.light_index = ($urandom_range(0, 1)) ? $urandom_range(0, 15) : $urandom();
        r.flicker_kind = 2'($urandom_range(0, 3));
        r.intensity_in = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00FFFFFF);
        r.pos_x_in = $urandom();
        r.pos_y_in = ($urandom_range(0, 1)) ? $urandom() : 32'($signed($urandom_range(0, 2000)) - 1000);
        r.pos_z_in = ($urandom_range(0, 7) == 0) ? 32'h7FFFFFF0 + $urandom_range(0, 15) : $urandom();
        return r;
    endfunction

    typedef struct {
        t_req r;
        bit   lit;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_req r;
        t_res lit;
        logic [STR_W-1:0] str_set[5];
        n_errors = 0;
        idle_cycles = 0;
        sent_any = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        strength_shadow = 19'd65536;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: extremes, every kind; pass-through rows carry a literal result
        r = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, K_NONE, 32'hFFFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h0};
        row = '{r, 1'b1};
        rows = {rows, row};
        r = '{32'h0, 32'h0, 32'h0, K_NONE, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF};
        row = '{r, 1'b1};
        rows = {rows, row};
        for (int k = 1; k < 4; k++) begin
            r = '{32'h0, 32'h0, 32'h0, k[1:0], 32'h00010000, 32'h0, 32'h0, 32'h0};
            row = '{r, 1'b0};
            rows = {rows, row};
            r = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, k[1:0], 32'hFFFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
            row = '{r, 1'b0};
            rows = {rows, row};
            r = '{32'h00018000, 32'h12345678, 32'd3, k[1:0], 32'h00200000,
                  32'h80000001, 32'h7FFFFFFE, 32'h00010000};
            row = '{r, 1'b0};
            rows = {rows, row};
        end
        foreach (rows[i]) begin
            lit.gain_out = GAIN_ONE;
            lit.intensity_out = rows[i].r.intensity_in;
            lit.pos_x_out = rows[i].r.pos_x_in;
            lit.pos_y_out = rows[i].r.pos_y_in;
            lit.pos_z_out = rows[i].r.pos_z_in;
            send_light(rows[i].r, rows[i].lit, lit);
        end
        drain_lights();

        // strength phases: zero disables, max exceeds 4.0 and saturates
        str_set = '{19'd0, 19'h7FFFF, 19'd262144, 19'd65536, 19'd1};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 5) write_strength(str_set[ph]);
            else write_strength(STR_W'($urandom_range(0, 19'h7FFFF)));
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                r = rand_light();
                send_light(r, 1'b0, lit);
            end
            drain_lights();
        end

        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/lfng_pkg.sv
design/lfng_noise.sv
design/light_flicker_noise_generator.sv
dv/light_flicker_noise_generator_tb.sv
